/* rtl/mnors_pkg.sv */
// shared types and constants for the midi note output encoder
`timescale 1ns / 1ps
`default_nettype none

package mnors_pkg;

    localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
    localparam logic [7:0] STATUS_CONTROL   = 8'hB0;
    localparam logic [7:0] CC_ALL_NOTES_OFF = 8'h7B;
    localparam logic [7:0] FIXED_VELOCITY   = 8'd80;
    localparam logic [7:0] BYTE_ZERO        = 8'h00;

    localparam int unsigned BURST_MAX = 5;

    localparam logic OP_PLAY    = 1'b0;
    localparam logic OP_ALL_OFF = 1'b1;

    typedef logic [2:0] burst_count_t;

    typedef struct packed {
        burst_count_t                  count;
        logic [BURST_MAX-1:0][7:0]     bytes;
    } burst_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

/* rtl/mnors_front.sv */
// front end: takes requests, tracks note state and builds byte bursts
`timescale 1ns / 1ps
`default_nettype none

module mnors_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             op,
    input  wire logic [7:0]       note_value,
    input  wire logic [7:0]       note_velocity,
    input  wire logic             q_full,
    output logic                  push,
    output mnors_pkg::burst_t     push_data
);

    logic                    velocity_mode_reg;
    logic                    status_on_reg;
    logic                    status_on_next;
    logic [7:0]              held_note_reg;
    logic [7:0]              held_note_next;
    logic                    accept;
    mnors_pkg::burst_t       burst;
    logic                    status_on_after;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic                    rs;
        mnors_pkg::burst_count_t cnt;
        logic [7:0]              vel;
        rs  = status_on_reg;
        cnt = '0;
        burst.bytes = '0;
        vel = velocity_mode_reg ? note_velocity : mnors_pkg::FIXED_VELOCITY;
        if (op == mnors_pkg::OP_ALL_OFF)
        begin
            burst.bytes[0] = mnors_pkg::STATUS_CONTROL;
            burst.bytes[1] = mnors_pkg::CC_ALL_NOTES_OFF;
            burst.bytes[2] = mnors_pkg::BYTE_ZERO;
            cnt = 3'd3;
            rs  = 1'b0;
        end
        else if (!note_velocity[7])
        begin
            // note-off for the held note
            if (!held_note_reg[7])
            begin
                if (!rs)
                begin
                    burst.bytes[cnt] = mnors_pkg::STATUS_NOTE_ON;
                    cnt = cnt + 3'd1;
                    rs  = 1'b1;
                end
                burst.bytes[cnt] = held_note_reg;
                cnt = cnt + 3'd1;
                burst.bytes[cnt] = mnors_pkg::BYTE_ZERO;
                cnt = cnt + 3'd1;
            end
            // note-on for the new note
            if ((note_value != 8'd0) && !note_value[7])
            begin
                if (!rs)
                begin
                    burst.bytes[cnt] = mnors_pkg::STATUS_NOTE_ON;
                    cnt = cnt + 3'd1;
                    rs  = 1'b1;
                end
                burst.bytes[cnt] = note_value;
                cnt = cnt + 3'd1;
                burst.bytes[cnt] = vel;
                cnt = cnt + 3'd1;
            end
        end
        burst.count     = cnt;
        status_on_after = rs;
    end

    always_comb
    begin
        status_on_next = status_on_reg;
        held_note_next = held_note_reg;
        if (accept)
        begin
            status_on_next = status_on_after;
            if (op == mnors_pkg::OP_PLAY)
            begin
                held_note_next = note_value;
            end
        end
    end

    assign push      = accept && (burst.count != '0);
    assign push_data = burst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_mode_reg <= 1'b1;
            status_on_reg     <= 1'b0;
            held_note_reg     <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                velocity_mode_reg <= cfg_wr_data;
            end
            status_on_reg <= status_on_next;
            held_note_reg <= held_note_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mnors_queue.sv */
// burst queue between front end and byte sender
`timescale 1ns / 1ps
`default_nettype none

module mnors_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire mnors_pkg::burst_t    push_data,
    input  wire logic                 pop,
    output mnors_pkg::burst_t         pop_data,
    output mnors_pkg::queue_status_t  status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mnors_pkg::burst_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/mnors_back.sv */
// back end: sends the bytes of each burst, one per cycle while out_ready is high
`timescale 1ns / 1ps
`default_nettype none

module mnors_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire mnors_pkg::burst_t  q_data,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              midi_byte,
    output logic                    last_byte
);

    mnors_pkg::burst_t        burst_reg;
    mnors_pkg::burst_count_t  idx_reg;
    mnors_pkg::burst_count_t  idx_next;
    logic                     busy_reg;
    logic                     busy_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [7:0]               midi_byte_reg;
    logic                     last_byte_reg;
    logic                     slot_free;
    logic                     advance;
    logic                     last_sel;

    assign slot_free = !out_valid_reg || out_ready;
    assign advance   = busy_reg && slot_free;
    assign last_sel  = (idx_reg == (burst_reg.count - 3'd1));
    assign pop       = !q_empty && (!busy_reg || (advance && last_sel));

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (advance && last_sel)
        begin
            busy_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            burst_reg <= q_data;
        end
        if (advance)
        begin
            midi_byte_reg <= burst_reg.bytes[idx_reg];
            last_byte_reg <= last_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign midi_byte = midi_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

`default_nettype wire

/* rtl/midi_note_output_running_status_top.sv */
// top level of the midi note output encoder with running status
//
//  channel   signals                                   dir  transaction
//  config    cfg_wr_en, cfg_wr_data                    in   velocity mode write
//  request   in_valid/in_ready, op, note_value,        in   one note request
//            note_velocity
//  bytes     out_valid/out_ready, midi_byte, last_byte out  one midi byte
//
//  a request is taken while the queue is not full and yields zero to five bytes
//  the byte sender emits one byte per cycle while out_ready is high; a burst is
//  2 to 5 bytes; queued bursts follow with no gap; a byteless request pushes none
//  up to QUEUE_DEPTH built bursts wait between front end and byte sender
//  reset clears running status and held note and sets velocity mode to 1
//  a stall on the byte side holds the sender; requests stop once the queue fills
`timescale 1ns / 1ps
`default_nettype none

module midi_note_output_running_status_top
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  note_value,
    input  wire logic [7:0]  note_velocity,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       midi_byte,
    output logic             last_byte
);

    logic                      push;
    logic                      pop;
    mnors_pkg::burst_t         push_data;
    mnors_pkg::burst_t         pop_data;
    mnors_pkg::queue_status_t  q_status;

    mnors_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .note_value    (note_value),
        .note_velocity (note_velocity),
        .q_full        (q_status.full),
        .push          (push),
        .push_data     (push_data)
    );

    mnors_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    mnors_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_status.empty),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .midi_byte (midi_byte),
        .last_byte (last_byte)
    );

    // an all-off request always leaves a burst waiting
    a_all_off_queued: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == mnors_pkg::OP_ALL_OFF) |=> !q_status.empty)
        else $error("all-off request did not reach the queue");

    // status bytes never close a burst
    a_status_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((midi_byte == mnors_pkg::STATUS_NOTE_ON) ||
                      (midi_byte == mnors_pkg::STATUS_CONTROL)) |-> !last_byte)
        else $error("status byte marked as last byte");

    // the queue never takes a burst while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("burst pushed into full queue");

endmodule

`default_nettype wire

/* verif/tb_midi_note_output_running_status_top.sv */
// testbench for the midi note output encoder: directed table, random requests, byte checks
`timescale 1ns / 1ps

module tb_midi_note_output_running_status_top;

    localparam logic [7:0] LEGATO_LIMIT     = 8'h80;
    localparam logic [7:0] NOTE_MAX         = 8'd127;
    localparam int unsigned DRAIN_CYCLES     = 16;
    localparam int unsigned LONG_HOLD_CYCLES = 150;
    localparam int unsigned RANDOM_PHASES    = 4;
    localparam int unsigned PHASE_ITEMS      = 40;

    typedef struct packed {
        logic            cfg_write;
        logic            op;
        logic [7:0]      note;
        logic [7:0]      vel;
        logic            typed;
        logic [2:0]      count;
        logic [0:4][7:0] bytes;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last_byte;
    } midi_out_t;

    // config rows carry the velocity mode in vel[0]
    localparam int unsigned DIRECTED_ROWS = 23;
    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{1'b0, mnors_pkg::OP_PLAY,    8'd60,  8'd100, 1'b1, 3'd5,
          {mnors_pkg::STATUS_NOTE_ON, mnors_pkg::BYTE_ZERO, mnors_pkg::BYTE_ZERO,
           8'd60, 8'd100}},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd127, 8'd127, 1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd1,   8'd0,   1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_ALL_OFF, 8'd255, 8'd255, 1'b1, 3'd3,
          {mnors_pkg::STATUS_CONTROL, mnors_pkg::CC_ALL_NOTES_OFF,
           mnors_pkg::BYTE_ZERO, 16'h0}},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd0,   8'd10,  1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd200, 8'd50,  1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd255, 8'd1,   1'b1, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd128, 8'd127, 1'b1, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd64,  8'd127, 1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd100, 8'd128, 1'b1, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd0,   8'd255, 1'b1, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd5,   8'd127, 1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_ALL_OFF, 8'd0,   8'd0,   1'b1, 3'd3,
          {mnors_pkg::STATUS_CONTROL, mnors_pkg::CC_ALL_NOTES_OFF,
           mnors_pkg::BYTE_ZERO, 16'h0}},
        '{1'b0, mnors_pkg::OP_ALL_OFF, 8'd170, 8'd85,  1'b1, 3'd3,
          {mnors_pkg::STATUS_CONTROL, mnors_pkg::CC_ALL_NOTES_OFF,
           mnors_pkg::BYTE_ZERO, 16'h0}},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd90,  8'd64,  1'b0, 3'd0, 40'h0},
        '{1'b1, mnors_pkg::OP_PLAY,    8'd0,   8'd0,   1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd33,  8'd1,   1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd127, 8'd255, 1'b1, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd10,  8'd127, 1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_ALL_OFF, 8'd85,  8'd170, 1'b1, 3'd3,
          {mnors_pkg::STATUS_CONTROL, mnors_pkg::CC_ALL_NOTES_OFF,
           mnors_pkg::BYTE_ZERO, 16'h0}},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd0,   8'd0,   1'b0, 3'd0, 40'h0},
        '{1'b1, mnors_pkg::OP_PLAY,    8'd0,   8'd1,   1'b0, 3'd0, 40'h0},
        '{1'b0, mnors_pkg::OP_PLAY,    8'd127, 8'd0,   1'b0, 3'd0, 40'h0}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       in_valid;
    logic       in_ready;
    logic       op;
    logic [7:0] note_value;
    logic [7:0] note_velocity;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] midi_byte;
    logic       last_byte;

    logic [7:0] tracked_status;
    logic [7:0] tracked_note;
    logic       tracked_velocity_mode;

    stim_row_t   pending_requests [$];
    midi_out_t   predicted_burst [$];
    midi_out_t   expected_bytes [$];
    int unsigned mismatch_count = 0;
    int unsigned burst_left = 0;
    bit          long_hold_request = 1'b0;

    midi_note_output_running_status_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .note_value    (note_value),
        .note_velocity (note_velocity),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .midi_byte     (midi_byte),
        .last_byte     (last_byte)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void emit_byte(input logic [7:0] value);
        midi_out_t item;
        item.midi_byte = value;
        item.last_byte = 1'b0;
        predicted_burst.push_back(item);
    endfunction

    function automatic void emit_note_status();
        if (tracked_status != mnors_pkg::STATUS_NOTE_ON)
        begin
            emit_byte(mnors_pkg::STATUS_NOTE_ON);
            tracked_status = mnors_pkg::STATUS_NOTE_ON;
        end
    endfunction

    function automatic void encode_request(input stim_row_t req);
        logic [7:0] velocity_out;
        midi_out_t  tail;
        predicted_burst.delete();
        if (req.op == mnors_pkg::OP_ALL_OFF)
        begin
            emit_byte(mnors_pkg::STATUS_CONTROL);
            emit_byte(mnors_pkg::CC_ALL_NOTES_OFF);
            emit_byte(mnors_pkg::BYTE_ZERO);
            tracked_status = mnors_pkg::STATUS_CONTROL;
        end
        else
        begin
            if (req.vel < LEGATO_LIMIT)
            begin
                if (tracked_note <= NOTE_MAX)
                begin
                    emit_note_status();
                    emit_byte(tracked_note);
                    emit_byte(mnors_pkg::BYTE_ZERO);
                end
                if (req.note != 8'd0 && req.note <= NOTE_MAX)
                begin
                    velocity_out = tracked_velocity_mode ? req.vel
                                                         : mnors_pkg::FIXED_VELOCITY;
                    emit_note_status();
                    emit_byte(req.note);
                    emit_byte(velocity_out);
                end
            end
            tracked_note = req.note;
        end
        if (predicted_burst.size() > 0)
        begin
            tail = predicted_burst.pop_back();
            tail.last_byte = 1'b1;
            predicted_burst.push_back(tail);
        end
    endfunction

    always @(posedge clk)
    begin : byte_check
        stim_row_t accepted;
        midi_out_t want;
        midi_out_t item;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                accepted = pending_requests.pop_front();
                encode_request(accepted);
                if (accepted.typed)
                begin
                    predicted_burst.delete();
                    for (int i = 0; i < accepted.count; i++)
                    begin
                        item.midi_byte = accepted.bytes[i];
                        item.last_byte = (i == accepted.count - 1);
                        predicted_burst.push_back(item);
                    end
                end
                foreach (predicted_burst[i])
                    expected_bytes.push_back(predicted_burst[i]);
            end
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("midi_byte %h arrived with nothing expected", midi_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (midi_byte !== want.midi_byte)
                    begin
                        $error("midi_byte mismatch: expected %h, got %h",
                               want.midi_byte, midi_byte);
                        mismatch_count++;
                    end
                    if (last_byte !== want.last_byte)
                    begin
                        $error("last_byte mismatch: expected %b, got %b",
                               want.last_byte, last_byte);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // receiver: rotating stall pattern, plus a long hold-off on request
    initial
    begin : receiver
        logic [7:0]  pattern;
        int unsigned slot;
        int unsigned hold;
        out_ready = 1'b0;
        forever
        begin
            pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            for (slot = 0; slot < 64; slot++)
            begin
                if (long_hold_request)
                begin
                    long_hold_request = 1'b0;
                    out_ready <= 1'b0;
                    for (hold = 0; hold < LONG_HOLD_CYCLES; hold++)
                        @(posedge clk);
                end
                out_ready <= pattern[slot % 8];
                @(posedge clk);
            end
        end
    end

    task automatic send_request(input stim_row_t req);
        pending_requests.push_back(req);
        in_valid      <= 1'b1;
        op            <= req.op;
        note_value    <= req.note;
        note_velocity <= req.vel;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0 || pending_requests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_velocity_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracked_velocity_mode = mode;
    endtask

    function automatic stim_row_t random_request();
        stim_row_t req;
        req = '0;
        req.op = ($urandom_range(0, 9) == 0) ? mnors_pkg::OP_ALL_OFF : mnors_pkg::OP_PLAY;
        case ($urandom_range(0, 9))
            0:       req.note = 8'd0;
            1, 2:    req.note = 8'($urandom_range(128, 255));
            default: req.note = 8'($urandom_range(1, 127));
        endcase
        if ($urandom_range(0, 4) == 0)
            req.vel = 8'($urandom_range(128, 255));
        else
            req.vel = 8'($urandom_range(0, 127));
        return req;
    endfunction

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned n;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        in_valid      = 1'b0;
        op            = mnors_pkg::OP_PLAY;
        note_value    = 8'd0;
        note_velocity = 8'd0;
        tracked_status        = 8'd0;
        tracked_note          = 8'd0;
        tracked_velocity_mode = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED[r].cfg_write)
            begin
                wait_drained();
                write_velocity_mode(DIRECTED[r].vel[0]);
            end
            else
            begin
                send_request(DIRECTED[r]);
                pace_sender();
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            write_velocity_mode(phase[0]);
            if (phase[0])
                long_hold_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_request(random_request());
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                else
                    pace_sender();
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
